// File: rtl/core/single_wire_sensor_frame_receiver_core_assert.svh
// Assertion macros for the single-wire sensor frame receiver.
`ifndef SINGLE_WIRE_SENSOR_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_FRAME_RECEIVER_CORE_ASSERT_SVH

// Checked out of reset only.
`define SWSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define SWSFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/swsfr_pkg.sv
// Shared constants, codes and types of the single-wire sensor frame receiver.
package swsfr_pkg;

  localparam int unsigned OpBits        = 3;
  localparam int unsigned StatusBits    = 3;
  localparam int unsigned TimeInBits    = 32;
  localparam int unsigned TimeBitsDef   = 32;
  localparam int unsigned EdgesPerFrame = 44;
  localparam int unsigned FirstDataEdge = 4;
  localparam int unsigned FrameBits     = 40;
  localparam int unsigned EdgeIdxBits   = 6;
  localparam int unsigned HumBits       = 16;
  localparam int unsigned TempBits      = 15;
  localparam int unsigned ThrBits       = 10;
  localparam int unsigned HoldBits      = 24;
  localparam int unsigned CfgIdxBits    = 1;
  localparam int unsigned CfgDataBits   = 24;

  localparam logic [ThrBits-1:0]  ThrRst  = ThrBits'(100);
  localparam logic [HoldBits-1:0] HoldRst = HoldBits'(2500000);

  typedef enum logic [OpBits-1:0] {
    OP_EDGE    = 3'd0,
    OP_START   = 3'd1,
    OP_PWR_ON  = 3'd2,
    OP_PWR_OFF = 3'd3,
    OP_QUERY   = 3'd4
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_OFF       = 3'd1,
    ST_TOO_SOON  = 3'd2,
    ST_FRAME_OK  = 3'd3,
    ST_CSUM_ERR  = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_PWR_REPLY = 3'd6
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_BIT_THRESHOLD = 1'b0,
    CFG_HOLDOFF       = 1'b1
  } cfg_idx_e;

  // Decoded frame contents
  typedef struct packed {
    logic                ok;
    logic [HumBits-1:0]  humidity;
    logic [TempBits-1:0] temperature;
    logic                negative;
  } frame_res_t;

endpackage

// File: rtl/core/swsfr_evt_if.sv
// Event channel: valid/ready handshake carrying op and timestamp.
interface swsfr_evt_if import swsfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OpBits-1:0]     op;
  logic [TimeInBits-1:0] time_us;

  modport source (output valid, op, time_us, input ready);
  modport sink   (input valid, op, time_us, output ready);
endinterface

// File: rtl/core/swsfr_res_if.sv
// Result channel: valid/ready handshake carrying status and decoded frame.
interface swsfr_res_if import swsfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [StatusBits-1:0] status;
  logic [HumBits-1:0]    humidity;
  logic [TempBits-1:0]   temperature;
  logic                  temperature_negative;
  logic [TimeInBits-1:0] start_time_us;
  logic                  powered;

  modport source (output valid, status, humidity, temperature, temperature_negative,
                  start_time_us, powered, input ready);
  modport sink   (input valid, status, humidity, temperature, temperature_negative,
                  start_time_us, powered, output ready);
endinterface

// File: rtl/core/single_wire_sensor_frame_receiver_core.sv
// Top level of the single-wire sensor frame receiver.
// Decodes timestamped events (falling edge, start, power on, power off, power query) of a
// single-wire temperature/humidity sensor into one result transaction per event. Every event
// is handled in the cycle it is accepted: the elapsed-time subtract and compare, the bit
// shift and the frame checksum sit between the event handshake and the result register, so
// the block takes one event per clock whenever the result side is not stalled; the result
// is valid in the cycle after acceptance. A finished result may sit in the output register
// while the next event is accepted in the same cycle it is taken. A start is refused while
// power is off or before holdoff_us has elapsed since power-on or the last start. Edges 4 to
// 43 after a start give one data bit each (interval above bit_threshold_us reads as one),
// the last of them closes the frame and reports humidity, temperature and sign when the byte
// sum matches; further edges are ignored with an overflow status. Time differences wrap
// modulo 2^TimeBits. Configuration writes take effect on the next event.
module single_wire_sensor_frame_receiver_core import swsfr_pkg::*; #(
  parameter int unsigned TimeBits = TimeBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  swsfr_evt_if.sink              evt_i,
  swsfr_res_if.source            res_o
);

  localparam logic [EdgeIdxBits-1:0] EdgeLimit = EdgeIdxBits'(EdgesPerFrame);
  localparam logic [EdgeIdxBits-1:0] DataEdge  = EdgeIdxBits'(FirstDataEdge);

  // Configuration registers
  logic [ThrBits-1:0]  thr_q;
  logic [HoldBits-1:0] hold_q;

  // Sensor state
  logic                   power_q, power_d;
  logic [TimeBits-1:0]    last_q, last_d;
  logic [TimeBits-1:0]    prev_q, prev_d;
  logic [EdgeIdxBits-1:0] idx_q, idx_d;
  logic [FrameBits-1:0]   frame_q, frame_d;

  // Result register
  logic                  res_valid_q;
  logic [StatusBits-1:0] status_q;
  logic [HumBits-1:0]    hum_q;
  logic [TempBits-1:0]   temp_q;
  logic                  neg_q;
  logic [TimeInBits-1:0] start_q;
  logic                  powered_q;

  logic                 evt_fire;
  logic [TimeBits-1:0]  now;
  logic [TimeBits-1:0]  interval;
  logic [TimeBits-1:0]  elapsed;
  logic                 data_bit;
  logic [FrameBits-1:0] frame_shift;
  logic                 last_edge;
  status_e              status;
  frame_res_t           chk;

  // Output register frees up in the same cycle it is drained
  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign evt_fire    = evt_i.valid && evt_i.ready;

  assign now      = TimeBits'(evt_i.time_us);
  assign interval = now - prev_q;
  assign elapsed  = now - last_q;

  // Frame with the bit of this edge shifted in
  assign data_bit    = (interval > TimeBits'(thr_q));
  assign frame_shift = {frame_q[FrameBits-2:0], data_bit};

  // Checksum is taken on the frame including the bit of the closing edge
  swsfr_frame_chk u_frame_chk (
    .frame_i (frame_shift),
    .res_o   (chk)
  );

  always_comb begin
    power_d   = power_q;
    last_d    = last_q;
    prev_d    = prev_q;
    idx_d     = idx_q;
    frame_d   = frame_q;
    last_edge = 1'b0;
    status    = ST_ACCEPTED;
    unique case (op_e'(evt_i.op))
      OP_EDGE: begin
        if (idx_q >= EdgeLimit) begin
          status = ST_OVERFLOW;
        end else begin
          if (idx_q >= DataEdge) begin
            frame_d = frame_shift;
          end
          prev_d = now;
          idx_d  = idx_q + 1'b1;
          if (idx_d == EdgeLimit) begin
            last_edge = 1'b1;
            status    = chk.ok ? ST_FRAME_OK : ST_CSUM_ERR;
          end
        end
      end
      OP_START: begin
        if (!power_q) begin
          status = ST_OFF;
        end else if (elapsed < TimeBits'(hold_q)) begin
          status = ST_TOO_SOON;
        end else begin
          last_d  = now;
          prev_d  = now;
          idx_d   = EdgeIdxBits'(1);
          frame_d = '0;
        end
      end
      OP_PWR_ON: begin
        power_d = 1'b1;
        last_d  = now;
      end
      OP_PWR_OFF: begin
        power_d = 1'b0;
      end
      default: begin
        // query and unused codes: no state change
        status = ST_PWR_REPLY;
      end
    endcase
  end

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrRst;
      hold_q <= HoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BIT_THRESHOLD: thr_q  <= cfg_data_i[ThrBits-1:0];
        CFG_HOLDOFF:       hold_q <= cfg_data_i[HoldBits-1:0];
      endcase
    end
  end

  // Sensor state advances once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= 1'b0;
      last_q  <= '0;
      prev_q  <= '0;
      idx_q   <= '0;
      frame_q <= '0;
    end else if (evt_fire) begin
      power_q <= power_d;
      last_q  <= last_d;
      prev_q  <= prev_d;
      idx_q   <= idx_d;
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (evt_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Payload: decoded fields only on a good frame
  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      status_q  <= status;
      hum_q     <= (last_edge && chk.ok) ? chk.humidity : '0;
      temp_q    <= (last_edge && chk.ok) ? chk.temperature : '0;
      neg_q     <= last_edge && chk.ok && chk.negative;
      start_q   <= TimeInBits'(last_d);
      powered_q <= power_d;
    end
  end

  assign res_o.valid                = res_valid_q;
  assign res_o.status               = status_q;
  assign res_o.humidity             = hum_q;
  assign res_o.temperature          = temp_q;
  assign res_o.temperature_negative = neg_q;
  assign res_o.start_time_us        = start_q;
  assign res_o.powered              = powered_q;

endmodule

// File: rtl/core/swsfr_frame_chk.sv
// Frame checksum test and field split of a completed 40-bit frame.
module swsfr_frame_chk import swsfr_pkg::*; (
  input  logic [FrameBits-1:0] frame_i,
  output frame_res_t           res_o
);

  logic [7:0] b0, b1, b2, b3, b4;
  logic [7:0] sum;

  assign b0 = frame_i[39:32];
  assign b1 = frame_i[31:24];
  assign b2 = frame_i[23:16];
  assign b3 = frame_i[15:8];
  assign b4 = frame_i[7:0];

  // 8-bit wrap-around sum
  assign sum = b0 + b1 + b2 + b3;

  assign res_o.ok          = (sum == b4);
  assign res_o.humidity    = {b0, b1};
  assign res_o.temperature = {b2[6:0], b3};
  assign res_o.negative    = b2[7];

endmodule

// File: rtl/core/swsfr_chk.sv
// Port-level checker for the frame receiver, bound to the top level.
`include "single_wire_sensor_frame_receiver_core_assert.svh"

module swsfr_chk import swsfr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [StatusBits-1:0] status,
  input logic [HumBits-1:0]    humidity,
  input logic [TempBits-1:0]   temperature,
  input logic                  negative,
  input logic                  powered
);

  `SWSFR_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !res_valid, "result valid during reset")

  `SWSFR_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(status) && $stable(humidity), "stalled result changed")

  `SWSFR_ASSERT(a_fields_only_on_ok, res_valid && (status != ST_FRAME_OK) |-> (humidity == '0) && (temperature == '0) && !negative, "frame fields set without a good frame")

  `SWSFR_ASSERT(a_refusal_vs_power, res_valid |-> !((status == ST_OFF && powered) || (status == ST_TOO_SOON && !powered)), "start refusal disagrees with power state")

endmodule

bind single_wire_sensor_frame_receiver_core swsfr_chk u_swsfr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid   (res_o.valid),
  .res_ready   (res_o.ready),
  .status      (res_o.status),
  .humidity    (res_o.humidity),
  .temperature (res_o.temperature),
  .negative    (res_o.temperature_negative),
  .powered     (res_o.powered)
);

// File: test/single_wire_sensor_frame_receiver_core_tb.sv
// Self-checking testbench for the single-wire sensor frame receiver core.
`timescale 1ns / 1ps

module single_wire_sensor_frame_receiver_core_tb;
  import swsfr_pkg::*;

  // Op codes outside the enum: the block answers them like a power query
  localparam logic [OpBits-1:0] OpSpareLo  = 3'd5;
  localparam logic [OpBits-1:0] OpSpareMid = 3'd6;
  localparam logic [OpBits-1:0] OpSpareHi  = 3'd7;

  localparam int unsigned RandomEvents = 2000;
  localparam int unsigned PhaseEvents  = 250;
  localparam int unsigned SettleCycles = 4;    // covers the result register, with margin
  localparam int unsigned MaxErrPrints = 50;
  localparam int unsigned DirCount     = 22;

  // One result transaction as the block presents it
  typedef struct packed {
    status_e               status;
    logic [HumBits-1:0]    humidity;
    logic [TempBits-1:0]   temperature;
    logic                  negative;
    logic [TimeInBits-1:0] start_us;
    logic                  powered;
  } sensor_reply_t;

  // Directed row: the event, and, where it is obvious, the reply pinned by hand
  typedef struct packed {
    logic [OpBits-1:0]     op;
    logic [TimeInBits-1:0] t;
    logic                  pinned;
    status_e               status;
    logic [TimeInBits-1:0] start_us;
    logic                  powered;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  swsfr_evt_if evt ();
  swsfr_res_if res ();

  single_wire_sensor_frame_receiver_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt),
    .res_o      (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block's state and registers, advanced once per accepted event
  // ---------------------------------------------------------------------------
  logic                  pwr_on_q;
  logic [TimeInBits-1:0] frame_start_t;   // power-on or last accepted start
  logic [TimeInBits-1:0] prev_fall_t;
  logic [EdgeIdxBits-1:0] fall_idx;
  logic [FrameBits-1:0]  frame_shift;
  logic [ThrBits-1:0]    thr_cfg;
  logic [HoldBits-1:0]   hold_cfg;

  sensor_reply_t replies_due [$];

  int unsigned err_cnt      = 0;
  int unsigned events_sent  = 0;
  int unsigned replies_seen = 0;
  int unsigned settings_cnt = 0;
  int unsigned frames_good  = 0;
  int unsigned frames_bad   = 0;
  int unsigned overflows    = 0;
  int unsigned refusals     = 0;

  bit evt_gaps_on   = 1'b1;
  bit res_stalls_on = 1'b1;
  logic [TimeInBits-1:0] now_us;   // running event clock, wraps freely

  // Work out the reply to one event and move the shadow state on
  function automatic sensor_reply_t decode_event(logic [OpBits-1:0] op,
                                                 logic [TimeInBits-1:0] now);
    sensor_reply_t         r;
    logic [TimeInBits-1:0] span;
    logic [7:0]            sum8;
    r = '0;
    case (op)
      OP_EDGE: begin
        if (fall_idx >= EdgesPerFrame) begin
          // frame already complete: edge dropped, nothing moves
          r.status = ST_OVERFLOW;
        end else begin
          span = now - prev_fall_t;
          if (fall_idx >= FirstDataEdge) begin
            frame_shift = {frame_shift[FrameBits-2:0], span > TimeInBits'(thr_cfg)};
          end
          prev_fall_t = now;
          fall_idx    = fall_idx + 1'b1;
          if (fall_idx == EdgesPerFrame) begin
            sum8 = frame_shift[39:32] + frame_shift[31:24] + frame_shift[23:16]
                 + frame_shift[15:8];
            if (sum8 != frame_shift[7:0]) begin
              r.status = ST_CSUM_ERR;
            end else begin
              r.status      = ST_FRAME_OK;
              r.humidity    = frame_shift[39:24];
              r.negative    = frame_shift[23];
              r.temperature = frame_shift[22:8];
            end
          end
        end
      end
      OP_START: begin
        span = now - frame_start_t;
        if (!pwr_on_q) begin
          r.status = ST_OFF;
        end else if (span < TimeInBits'(hold_cfg)) begin
          r.status = ST_TOO_SOON;
        end else begin
          frame_start_t = now;
          prev_fall_t   = now;
          fall_idx      = EdgeIdxBits'(1);
          frame_shift   = '0;
        end
      end
      OP_PWR_ON: begin
        pwr_on_q      = 1'b1;
        frame_start_t = now;
      end
      OP_PWR_OFF: pwr_on_q = 1'b0;
      default:    r.status = ST_PWR_REPLY;
    endcase
    r.start_us = frame_start_t;
    r.powered  = pwr_on_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Event side: one transaction per call, random gap before it
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [OpBits-1:0] op, input logic [TimeInBits-1:0] t,
                            input logic pinned = 1'b0,
                            input sensor_reply_t pinned_reply = '0);
    int unsigned   gap;
    sensor_reply_t predicted;
    gap = evt_gaps_on ? $urandom_range(0, 7) : 0;
    // valid stays high between back-to-back transactions
    if (gap != 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid   <= 1'b1;
    evt.op      <= op;
    evt.time_us <= t;
    do @(posedge clk_i); while (!evt.ready);
    predicted = decode_event(op, t);
    replies_due.push_back(pinned ? pinned_reply : predicted);
    events_sent++;
  endtask

  // Registers only change with the block idle and every reply in
  task automatic apply_settings(input logic [ThrBits-1:0] thr,
                                input logic [HoldBits-1:0] hold);
    evt.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BIT_THRESHOLD;
    cfg_data_i <= CfgDataBits'(thr);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HOLDOFF;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_cfg  = thr;
    hold_cfg = hold;
    settings_cnt++;
  endtask

  // A full reading: power up if needed, start once the holdoff is over, then
  // three preamble edges and forty data edges carrying humidity, temperature
  // and checksum. Now and then the sequence is disturbed or runs past its end.
  task automatic run_frame();
    logic [31:0]          payload;
    logic [7:0]           csum;
    logic [FrameBits-1:0] bits;
    logic [TimeInBits-1:0] gap_us;
    int unsigned          disturb_at;
    int unsigned          k;
    payload = $urandom();
    csum    = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
    if ($urandom_range(0, 6) == 0) csum ^= 8'($urandom_range(1, 255));
    bits = {payload, csum};

    if (!pwr_on_q || $urandom_range(0, 4) == 0) begin
      now_us += $urandom_range(0, 1000);
      send_event(OP_PWR_ON, now_us);
    end
    // an early start now and then, refused as too soon
    if (hold_cfg != 0 && $urandom_range(0, 5) == 0) begin
      send_event(OP_START, frame_start_t + $urandom_range(0, int'(hold_cfg) - 1));
    end
    now_us = frame_start_t + TimeInBits'(hold_cfg);
    if ($urandom_range(0, 3) != 0) now_us += $urandom_range(1, 3000);
    send_event(OP_START, now_us);

    disturb_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, EdgesPerFrame - 1) : 0;
    for (k = 1; k < EdgesPerFrame; k++) begin
      if (k == disturb_at) begin
        case ($urandom_range(0, 3))
          0: send_event(OP_QUERY, now_us);
          1: send_event(OP_PWR_ON, now_us);     // start time moves to here
          2: send_event(OP_PWR_OFF, now_us);    // edges still count
          default: break;                       // reading cut short
        endcase
      end
      if (k < FirstDataEdge) begin
        gap_us = $urandom_range(0, 200);
      end else if (bits[EdgesPerFrame - 1 - k]) begin
        gap_us = TimeInBits'(thr_cfg) + $urandom_range(1, 300);
      end else begin
        gap_us = $urandom_range(0, int'(thr_cfg));
      end
      now_us += gap_us;
      send_event(OP_EDGE, now_us);
    end

    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        now_us += $urandom_range(0, 500);
        send_event(OP_EDGE, now_us);
      end
    end
  endtask

  // Any op, any time: unused codes, stray edges, starts in odd states
  task automatic run_noise();
    logic [OpBits-1:0] op;
    repeat ($urandom_range(1, 4)) begin
      op     = OpBits'($urandom_range(0, 7));
      now_us = ($urandom_range(0, 1) == 0) ? $urandom() : now_us + $urandom_range(0, 5000);
      send_event(op, now_us);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall before each transaction is taken
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_cycles;
    res.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      hold_cycles = res_stalls_on ? $urandom_range(0, 7) : 0;
      if (hold_cycles != 0) begin
        res.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (err_cnt < MaxErrPrints) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
      err_cnt++;
    end
  endfunction

  // Every accepted result against the oldest outstanding expectation
  always @(posedge clk_i) begin : check_results
    sensor_reply_t want;
    if (rst_ni && res.valid && res.ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        if (err_cnt < MaxErrPrints) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, res.status);
        end
        err_cnt++;
      end else begin
        want = replies_due.pop_front();
        check_field("status", 32'(want.status), 32'(res.status));
        check_field("humidity", 32'(want.humidity), 32'(res.humidity));
        check_field("temperature", 32'(want.temperature), 32'(res.temperature));
        check_field("temperature_negative", 32'(want.negative),
                    32'(res.temperature_negative));
        check_field("start_time_us", want.start_us, res.start_time_us);
        check_field("powered", 32'(want.powered), 32'(res.powered));
        case (want.status)
          ST_FRAME_OK:           frames_good++;
          ST_CSUM_ERR:           frames_bad++;
          ST_OVERFLOW:           overflows++;
          ST_OFF, ST_TOO_SOON:   refusals++;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table, reset register values. Pinned rows carry the reply that
  // follows plainly from the state; the rest go through the shadow model.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [DirCount] = '{
    '{OP_QUERY,   32'h0000_0000, 1'b1, ST_PWR_REPLY, 32'h0000_0000, 1'b0},
    '{OpSpareLo,  32'hFFFF_FFFF, 1'b1, ST_PWR_REPLY, 32'h0000_0000, 1'b0},
    '{OpSpareMid, 32'hAAAA_AAAA, 1'b1, ST_PWR_REPLY, 32'h0000_0000, 1'b0},
    '{OpSpareHi,  32'h5555_5555, 1'b1, ST_PWR_REPLY, 32'h0000_0000, 1'b0},
    // start with power off
    '{OP_START,   32'hFFFF_FFFF, 1'b1, ST_OFF,       32'h0000_0000, 1'b0},
    // edges before any start still advance the index
    '{OP_EDGE,    32'd10,        1'b1, ST_ACCEPTED,  32'h0000_0000, 1'b0},
    '{OP_EDGE,    32'd200,       1'b1, ST_ACCEPTED,  32'h0000_0000, 1'b0},
    '{OP_PWR_OFF, 32'd300,       1'b1, ST_ACCEPTED,  32'h0000_0000, 1'b0},
    '{OP_PWR_ON,  32'd1000,      1'b1, ST_ACCEPTED,  32'd1000,      1'b1},
    // power on while on: time taken again
    '{OP_PWR_ON,  32'd2000,      1'b1, ST_ACCEPTED,  32'd2000,      1'b1},
    // one microsecond short of the holdoff, then exactly on it
    '{OP_START,   32'd2501999,   1'b1, ST_TOO_SOON,  32'd2000,      1'b1},
    '{OP_START,   32'd2502000,   1'b1, ST_ACCEPTED,  32'd2502000,   1'b1},
    '{OP_EDGE,    32'd2502080,   1'b0, ST_ACCEPTED,  32'h0,         1'b0},
    '{OP_EDGE,    32'd2502300,   1'b0, ST_ACCEPTED,  32'h0,         1'b0},
    '{OP_QUERY,   32'd2503000,   1'b1, ST_PWR_REPLY, 32'd2502000,   1'b1},
    '{OP_PWR_OFF, 32'd2503100,   1'b1, ST_ACCEPTED,  32'd2502000,   1'b0},
    '{OP_START,   32'd2503200,   1'b1, ST_OFF,       32'd2502000,   1'b0},
    // power on mid-frame, close to the top of the time range
    '{OP_PWR_ON,  32'hFFFF_FF00, 1'b1, ST_ACCEPTED,  32'hFFFF_FF00, 1'b1},
    // holdoff measured across the wrap
    '{OP_START,   32'h0026_249F, 1'b1, ST_TOO_SOON,  32'hFFFF_FF00, 1'b1},
    '{OP_START,   32'h0026_24A0, 1'b1, ST_ACCEPTED,  32'h0026_24A0, 1'b1},
    // an edge interval that wraps, then a near-full-range one
    '{OP_EDGE,    32'h0026_249F, 1'b0, ST_ACCEPTED,  32'h0,         1'b0},
    '{OP_EDGE,    32'hFFFF_FFFF, 1'b0, ST_ACCEPTED,  32'h0,         1'b0}
  };

  // Register settings per phase: extremes and reset values first, then random
  logic [ThrBits-1:0]  phase_thr  [5] = '{10'd0, 10'd1023, 10'd100, 10'd1023, 10'd0};
  logic [HoldBits-1:0] phase_hold [5] = '{24'd0, 24'hFF_FFFF, 24'd2500000, 24'd0, 24'hFF_FFFF};

  initial begin : stimulus
    int unsigned   phase;
    int unsigned   phase_end;
    int unsigned   target;
    sensor_reply_t pinned_reply;
    logic [ThrBits-1:0]  thr_next;
    logic [HoldBits-1:0] hold_next;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BIT_THRESHOLD;
    cfg_data_i  = '0;
    evt.valid   = 1'b0;
    evt.op      = OP_QUERY;
    evt.time_us = '0;

    // shadow state as the block comes out of reset
    pwr_on_q      = 1'b0;
    frame_start_t = '0;
    prev_fall_t   = '0;
    fall_idx      = '0;
    frame_shift   = '0;
    thr_cfg       = ThrRst;
    hold_cfg      = HoldRst;
    now_us        = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      pinned_reply = '{dir_rows[i].status, '0, '0, 1'b0,
                       dir_rows[i].start_us, dir_rows[i].powered};
      send_event(dir_rows[i].op, dir_rows[i].t, dir_rows[i].pinned, pinned_reply);
    end
    now_us = dir_rows[DirCount-1].t;

    // Random part in phases, each under its own register setting. Mostly
    // well-formed readings with random content, the rest stray events.
    target = events_sent + RandomEvents;
    phase  = 0;
    while (events_sent < target) begin
      if (phase < 5) begin
        thr_next  = phase_thr[phase];
        hold_next = phase_hold[phase];
      end else begin
        thr_next  = ThrBits'($urandom_range(0, 1023));
        hold_next = HoldBits'($urandom_range(0, 24'hFF_FFFF));
      end
      apply_settings(thr_next, hold_next);
      // one phase runs flat out on both sides
      evt_gaps_on   = (phase != 2) && ($urandom_range(0, 3) != 0);
      res_stalls_on = (phase != 2) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) now_us = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      phase_end = events_sent + PhaseEvents;
      while (events_sent < phase_end && events_sent < target) begin
        if ($urandom_range(0, 9) < 7) run_frame();
        else run_noise();
      end
      phase++;
    end

    // let the last replies drain, with a bound
    evt.valid <= 1'b0;
    for (int c = 0; c < 2000 && replies_due.size() != 0; c++) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      $display("%0t: %0d results still expected, actual none", $time, replies_due.size());
      err_cnt += replies_due.size();
    end
    repeat (SettleCycles * 2) @(posedge clk_i);

    $display("Ran %0d events under %0d register settings, %0d results checked.",
             events_sent, settings_cnt, replies_seen);
    $display("Good frames %0d, checksum errors %0d, overflow edges %0d, refused starts %0d.",
             frames_good, frames_bad, overflows, refusals);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results outstanding.", replies_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
